/* hw/rtl/software_timer_slot_bank_top_defines.svh */
// Assertion macros shared by the timer slot bank RTL
`ifndef SOFTWARE_TIMER_SLOT_BANK_TOP_DEFINES_SVH
`define SOFTWARE_TIMER_SLOT_BANK_TOP_DEFINES_SVH
// assert that an implication holds on every clock edge out of reset
`define STSB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// assert that an implication holds in the cycle after the antecedent
`define STSB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* hw/rtl/stsb_pkg.sv */
// Shared types and constants for the timer slot bank
package stsb_pkg;
    localparam int SLOTS = 16;
    localparam int SLOT_BITS = $clog2(SLOTS);
    localparam int ID_BITS = 8;

    localparam logic [2:0] REQ_MS_TICK = 3'd0;
    localparam logic [2:0] REQ_S_TICK  = 3'd1;
    localparam logic [2:0] REQ_START   = 3'd2;
    localparam logic [2:0] REQ_STOP    = 3'd3;
    localparam logic [2:0] REQ_QUERY   = 3'd4;

    typedef struct packed {
        logic                 load;
        logic                 tick;
        logic                 slot_step;
        logic                 remove_hit;
        logic                 place;
        logic [SLOT_BITS-1:0] idx;
        logic                 sel_long;
    } stsb_cmd_t;

    typedef struct packed {
        logic                 due;
        logic [ID_BITS-1:0]   due_id;
        logic                 hit;
        logic                 has_free;
    } stsb_stat_t;
endpackage

/* hw/rtl/stsb_datapath.sv */
// Slot tables, tick counters and slot compare logic
module stsb_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  stsb_pkg::stsb_cmd_t           cmd,
    input  logic [stsb_pkg::ID_BITS-1:0]  id,
    input  logic [31:0]                   period,
    input  logic                          periodic,
    output stsb_pkg::stsb_stat_t          stat
);
    localparam int N = stsb_pkg::SLOTS;
    localparam int SB = stsb_pkg::SLOT_BITS;

    logic [N-1:0] valid_reg [2];
    logic [N-1:0] valid_next [2];
    logic [stsb_pkg::ID_BITS-1:0] handle_reg [2][N];
    logic [31:0] interval_reg [2][N];
    logic [N-1:0] repeat_reg [2];
    logic [31:0] deadline_reg [2][N];
    logic [31:0] count_reg [2];
    logic [31:0] count_next [2];

    logic          b;
    logic [31:0]   now;
    logic [31:0]   dl;
    logic          due;
    logic [N-1:0]  hits;
    logic          hit;
    logic [SB-1:0] hit_idx;
    logic [N-1:0]  vrem;
    logic          has_free;
    logic [SB-1:0] free_idx;

    assign b   = cmd.sel_long;
    assign now = count_reg[b];
    assign dl  = deadline_reg[b][cmd.idx];
    assign due = valid_reg[b][cmd.idx] && (b ? (now >= dl) : (now == dl));

    always_comb
    begin
        hit = 1'b0;
        hit_idx = '0;
        for (int i = N - 1; i >= 0; i--)
        begin
            hits[i] = valid_reg[b][i] && (handle_reg[b][i] == id);
            if (hits[i])
            begin
                hit = 1'b1;
                hit_idx = SB'(i);
            end
        end
    end

    always_comb
    begin
        vrem = valid_reg[b];
        if (hit)
            vrem[hit_idx] = 1'b0;
        has_free = 1'b0;
        free_idx = '0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (!vrem[i])
            begin
                has_free = 1'b1;
                free_idx = SB'(i);
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        count_next = count_reg;
        if (cmd.tick)
            count_next[b] = count_reg[b] + 32'd1;
        if (cmd.slot_step && due && !repeat_reg[b][cmd.idx])
            valid_next[b][cmd.idx] = 1'b0;
        if (cmd.remove_hit || cmd.place)
            valid_next[b] = vrem;
        if (cmd.place && has_free)
            valid_next[b][free_idx] = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= '0;
            valid_reg[1] <= '0;
            count_reg[0] <= '0;
            count_reg[1] <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.slot_step && due && repeat_reg[b][cmd.idx])
            deadline_reg[b][cmd.idx] <= now + interval_reg[b][cmd.idx];
        if (cmd.place && has_free)
        begin
            handle_reg[b][free_idx]   <= id;
            interval_reg[b][free_idx] <= period;
            repeat_reg[b][free_idx]   <= periodic;
            deadline_reg[b][free_idx] <= now + period;
        end
    end

    assign stat.due      = due;
    assign stat.due_id   = handle_reg[b][cmd.idx];
    assign stat.hit      = hit;
    assign stat.has_free = has_free;
endmodule

/* hw/rtl/stsb_ctrl.sv */
// Request sequencer and result register for the timer slot bank
`include "software_timer_slot_bank_top_defines.svh"
module stsb_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [2:0]                    req_type,
    input  logic [stsb_pkg::ID_BITS-1:0]  handle,
    input  logic                          is_long,
    input  logic [31:0]                   period,
    input  logic                          periodic,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          event_kind,
    output logic [7:0]                    event_id,
    output logic                          ok,
    output logic                          running,
    output logic                          last,
    output stsb_pkg::stsb_cmd_t           cmd,
    output logic [stsb_pkg::ID_BITS-1:0]  id_q,
    output logic [31:0]                   period_q,
    output logic                          periodic_q,
    input  stsb_pkg::stsb_stat_t          stat
);
    localparam int SB = stsb_pkg::SLOT_BITS;

    typedef enum logic [1:0] {IDLE, TICK, SCAN, STATUS} state_t;

    state_t        state_reg;
    logic [2:0]    req_reg;
    logic          long_reg;
    logic [SB-1:0] idx_reg;
    logic          out_full;
    logic          can_load;
    logic          emit;

    assign out_full = out_valid && !out_ready;
    assign in_ready = (state_reg == IDLE);
    assign can_load = !out_full;
    assign emit     = can_load && (((state_reg == SCAN) && stat.due) || (state_reg == STATUS));

    always_comb
    begin
        cmd = '0;
        cmd.idx = idx_reg;
        cmd.sel_long = long_reg;
        unique case (state_reg)
            TICK:    cmd.tick = 1'b1;
            SCAN:    cmd.slot_step = can_load;
            STATUS:
            begin
                cmd.remove_hit = can_load && (req_reg == stsb_pkg::REQ_STOP);
                cmd.place = can_load && (req_reg == stsb_pkg::REQ_START);
            end
            default: cmd = cmd;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            id_q       <= handle;
            period_q   <= period;
            periodic_q <= periodic;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= IDLE;
            req_reg    <= '0;
            long_reg   <= 1'b0;
            idx_reg    <= '0;
            out_valid  <= 1'b0;
            event_kind <= 1'b0;
            event_id   <= '0;
            ok         <= 1'b0;
            running    <= 1'b0;
            last       <= 1'b0;
        end
        else
        begin
            out_valid <= emit || out_full;
            unique case (state_reg)
                IDLE:
                begin
                    if (in_valid)
                    begin
                        req_reg <= req_type;
                        idx_reg <= '0;
                        if (req_type == stsb_pkg::REQ_MS_TICK)
                        begin
                            long_reg  <= 1'b0;
                            state_reg <= TICK;
                        end
                        else if (req_type == stsb_pkg::REQ_S_TICK)
                        begin
                            long_reg  <= 1'b1;
                            state_reg <= TICK;
                        end
                        else
                        begin
                            long_reg  <= is_long;
                            state_reg <= STATUS;
                        end
                    end
                end
                TICK:    state_reg <= SCAN;
                SCAN:
                begin
                    if (can_load)
                    begin
                        if (stat.due)
                        begin
                            event_kind <= 1'b0;
                            event_id   <= 8'(stat.due_id);
                            ok         <= 1'b1;
                            running    <= 1'b0;
                            last       <= 1'b0;
                        end
                        idx_reg <= idx_reg + SB'(1);
                        if (idx_reg == SB'(stsb_pkg::SLOTS - 1))
                            state_reg <= STATUS;
                    end
                end
                STATUS:
                begin
                    if (can_load)
                    begin
                        event_kind <= 1'b1;
                        event_id   <= 8'(id_q);
                        last       <= 1'b1;
                        running    <= (req_reg == stsb_pkg::REQ_QUERY) && stat.hit;
                        case (req_reg) inside
                            stsb_pkg::REQ_START: ok <= stat.has_free;
                            stsb_pkg::REQ_MS_TICK, stsb_pkg::REQ_S_TICK,
                            stsb_pkg::REQ_STOP, stsb_pkg::REQ_QUERY: ok <= 1'b1;
                            default: ok <= 1'b0;
                        endcase
                        state_reg <= IDLE;
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

    `STSB_ASSERT_IMP(a_no_overwrite, clk, rst_n, out_full, !cmd.slot_step && !cmd.place)
    `STSB_ASSERT_NEXT(a_tick, clk, rst_n, state_reg == TICK, state_reg == SCAN && idx_reg == '0)
    `STSB_ASSERT_IMP(a_busy_no_accept, clk, rst_n, state_reg != IDLE, !in_ready)
endmodule

/* hw/rtl/software_timer_slot_bank_top.sv */
// Top level of the timer slot bank
// Two 16-slot timer tables (millisecond and second). A start, stop or query
// goes to the status state, which loads its status item into the output
// register, and the next request is taken once the block is back in idle.
// A tick advances the counter, compares one slot per cycle over all 16 slots,
// loads the status item and goes back to idle. Only one request is in flight
// at a time, and the scan and the status item pause whenever the output
// register is still held.
module software_timer_slot_bank_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [2:0]                    req_type,
    input  logic [7:0]                    handle,
    input  logic                          is_long,
    input  logic [31:0]                   period,
    input  logic                          periodic,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          event_kind,
    output logic [7:0]                    event_id,
    output logic                          ok,
    output logic                          running,
    output logic                          last
);
    stsb_pkg::stsb_cmd_t          cmd;
    stsb_pkg::stsb_stat_t         stat;
    logic [stsb_pkg::ID_BITS-1:0] id_q;
    logic [31:0]                  period_q;
    logic                         periodic_q;

    stsb_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .handle(handle[stsb_pkg::ID_BITS-1:0]),
        .is_long(is_long), .period(period), .periodic(periodic),
        .out_valid(out_valid), .out_ready(out_ready),
        .event_kind(event_kind), .event_id(event_id), .ok(ok),
        .running(running), .last(last),
        .cmd(cmd), .id_q(id_q), .period_q(period_q), .periodic_q(periodic_q),
        .stat(stat)
    );

    stsb_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .id(id_q), .period(period_q), .periodic(periodic_q), .stat(stat)
    );
endmodule

/* dv/software_timer_slot_bank_top_test.sv */
// Self-checking testbench for the timer slot bank: directed and random traffic, predicted events
module software_timer_slot_bank_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [2:0]  kind;
        logic [7:0]  id;
        logic        lng;
        logic [31:0] per;
        logic        rep;
    } request_t;

    typedef struct packed {
        logic       event_kind;
        logic [7:0] event_id;
        logic       ok;
        logic       running;
        logic       last;
    } event_t;

    localparam int NSLOT = 16;
    localparam int WATCHDOG = 20000;

    logic clk, rst_n;
    logic in_valid, in_ready;
    logic [2:0] req_type;
    logic [7:0] handle;
    logic is_long;
    logic [31:0] period;
    logic periodic;
    logic out_valid, out_ready;
    logic event_kind;
    logic [7:0] event_id;
    logic ok, running, last;

    software_timer_slot_bank_top dut (.*);

    // predictor state: index 0 short table, 1 long table
    logic        tab_used [2][NSLOT];
    logic [7:0]  tab_id   [2][NSLOT];
    logic [31:0] tab_per  [2][NSLOT];
    logic        tab_rep  [2][NSLOT];
    logic [31:0] tab_due  [2][NSLOT];
    logic [31:0] tick_cnt [2];

    request_t pending_reqs[$];
    event_t   expected_events[$];
    int errors, accepted_reqs, seen_events, expiries, idle_cycles;
    int hold_off;
    bit done_stim;

    always
    begin
        clk = 1'b1; #5;
        clk = 1'b0; #5;
    end

    function automatic event_t mk_event(logic k, logic [7:0] id, logic o, logic r, logic l);
        event_t e;
        e.event_kind = k; e.event_id = id; e.ok = o; e.running = r; e.last = l;
        return e;
    endfunction

    function automatic int find_timer(int t, logic [7:0] id);
        for (int i = 0; i < NSLOT; i++)
            if (tab_used[t][i] && tab_id[t][i] == id)
                return i;
        return -1;
    endfunction

    function automatic void predict_events(request_t r);
        int t, s;
        logic o, run;
        logic [31:0] now;
        bit due;
        t = r.lng ? 1 : 0;
        o = 1'b1;
        run = 1'b0;
        case (r.kind) inside
            stsb_pkg::REQ_MS_TICK, stsb_pkg::REQ_S_TICK:
            begin
                t = (r.kind == stsb_pkg::REQ_S_TICK) ? 1 : 0;
                tick_cnt[t] = tick_cnt[t] + 32'd1;
                now = tick_cnt[t];
                for (int i = 0; i < NSLOT; i++)
                begin
                    if (!tab_used[t][i])
                        continue;
                    due = t ? (now >= tab_due[t][i]) : (now == tab_due[t][i]);
                    if (!due)
                        continue;
                    if (tab_rep[t][i])
                        tab_due[t][i] = now + tab_per[t][i];
                    else
                        tab_used[t][i] = 1'b0;
                    expected_events.push_back(mk_event(1'b0, tab_id[t][i], 1'b1, 1'b0, 1'b0));
                    expiries++;
                end
            end
            stsb_pkg::REQ_START:
            begin
                s = find_timer(t, r.id);
                if (s >= 0)
                    tab_used[t][s] = 1'b0;
                o = 1'b0;
                for (int i = 0; i < NSLOT; i++)
                    if (!tab_used[t][i])
                    begin
                        tab_used[t][i] = 1'b1;
                        tab_id[t][i] = r.id;
                        tab_per[t][i] = r.per;
                        tab_rep[t][i] = r.rep;
                        tab_due[t][i] = tick_cnt[t] + r.per;
                        o = 1'b1;
                        break;
                    end
            end
            stsb_pkg::REQ_STOP:
            begin
                s = find_timer(t, r.id);
                if (s >= 0)
                    tab_used[t][s] = 1'b0;
            end
            stsb_pkg::REQ_QUERY: run = (find_timer(t, r.id) >= 0);
            default: o = 1'b0;
        endcase
        expected_events.push_back(mk_event(1'b1, r.id, o, run, 1'b1));
    endfunction

    function automatic request_t mk_req(logic [2:0] k, logic [7:0] id, logic l,
                                        logic [31:0] p, logic rp);
        request_t r;
        r.kind = k; r.id = id; r.lng = l; r.per = p; r.rep = rp;
        return r;
    endfunction

    function automatic int gap_len();
        return ($urandom_range(0, 9) < 7) ? $urandom_range(0, 2) : $urandom_range(5, 30);
    endfunction

    // driver
    int in_gap;
    logic in_ready_seen;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gap <= 0;
        end
        else if (!in_valid || in_ready_seen)
        begin
            if (in_gap > 0 || pending_reqs.size() == 0)
            begin
                in_valid <= 1'b0;
                if (in_gap > 0)
                    in_gap <= in_gap - 1;
            end
            else
            begin
                request_t r;
                r = pending_reqs.pop_front();
                in_valid <= 1'b1;
                req_type <= r.kind;
                handle <= r.id;
                is_long <= r.lng;
                period <= r.per;
                periodic <= r.rep;
                in_gap <= gap_len();
            end
        end
    end

    always @(posedge clk)
    begin
        in_ready_seen <= 1'b0;
        if (rst_n && in_valid && in_ready)
        begin
            in_ready_seen <= 1'b1;
            accepted_reqs++;
            predict_events(mk_req(req_type, handle, is_long, period, periodic));
        end
    end

    // receiver readiness
    int out_gap;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_gap <= 0;
        end
        else if (hold_off > 0)
        begin
            out_ready <= 1'b0;
            hold_off <= hold_off - 1;
        end
        else if (out_gap > 0)
        begin
            out_ready <= 1'b0;
            out_gap <= out_gap - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                out_gap <= gap_len();
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            event_t got, want;
            got = mk_event(event_kind, event_id, ok, running, last);
            seen_events++;
            if (expected_events.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected item kind=%0d id=%0d ok=%0d run=%0d last=%0d",
                         $time, got.event_kind, got.event_id, got.ok, got.running, got.last);
            end
            else
            begin
                want = expected_events.pop_front();
                if (got != want)
                begin
                    errors++;
                    $display("%0t: mismatch expected kind=%0d id=%0d ok=%0d run=%0d last=%0d",
                             $time, want.event_kind, want.event_id, want.ok, want.running,
                             want.last);
                    $display("%0t:          actual   kind=%0d id=%0d ok=%0d run=%0d last=%0d",
                             $time, got.event_kind, got.event_id, got.ok, got.running,
                             got.last);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("software_timer_slot_bank_top_test failed");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || in_valid || expected_events.size() != 0)
            @(posedge clk);
    endtask

    function automatic request_t rand_req();
        int sel;
        logic [31:0] p, q;
        logic [7:0] any_id, near_id;
        logic l, rp;
        sel = $urandom_range(0, 99);
        p = ($urandom_range(0, 9) < 8) ? 32'($urandom_range(0, 6)) : 32'($urandom());
        q = $urandom();
        any_id = 8'($urandom());
        near_id = 8'($urandom_range(0, 11));
        l = 1'($urandom());
        rp = 1'($urandom());
        if (sel < 30)
            return mk_req(stsb_pkg::REQ_MS_TICK, any_id, l, q, rp);
        else if (sel < 45)
            return mk_req(stsb_pkg::REQ_S_TICK, any_id, l, q, rp);
        else if (sel < 72)
            return mk_req(stsb_pkg::REQ_START, near_id, l, p, rp);
        else if (sel < 84)
            return mk_req(stsb_pkg::REQ_STOP, near_id, l, p, rp);
        else if (sel < 96)
            return mk_req(stsb_pkg::REQ_QUERY, near_id, l, p, rp);
        else
            return mk_req(3'($urandom_range(5, 7)), any_id, l, q, rp);
    endfunction

    initial
    begin
        errors = 0; accepted_reqs = 0; seen_events = 0; expiries = 0;
        idle_cycles = 0; hold_off = 0;
        for (int t = 0; t < 2; t++)
        begin
            tick_cnt[t] = 32'd0;
            for (int i = 0; i < NSLOT; i++)
                tab_used[t][i] = 1'b0;
        end
        rst_n = 1'b0;
        req_type = '0; handle = '0; is_long = 1'b0; period = '0; periodic = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b0;
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, full table, stop of absent id, long wrap, bad request
        pending_reqs.push_back(mk_req(stsb_pkg::REQ_START, 8'hFF, 1'b0, 32'd1, 1'b1));
        pending_reqs.push_back(mk_req(stsb_pkg::REQ_START, 8'h00, 1'b1, 32'hFFFF_FFFF, 1'b0));
        pending_reqs.push_back(mk_req(stsb_pkg::REQ_START, 8'h55, 1'b1, 32'd0, 1'b0));
        pending_reqs.push_back(mk_req(stsb_pkg::REQ_START, 8'hAA, 1'b0, 32'd0, 1'b1));
        pending_reqs.push_back(mk_req(stsb_pkg::REQ_QUERY, 8'hFF, 1'b0, 32'd0, 1'b0));
        pending_reqs.push_back(mk_req(stsb_pkg::REQ_QUERY, 8'hFF, 1'b1, 32'd0, 1'b0));
        pending_reqs.push_back(mk_req(stsb_pkg::REQ_MS_TICK, 8'h12, 1'b1, 32'hFFFF_FFFF, 1'b1));
        pending_reqs.push_back(mk_req(stsb_pkg::REQ_S_TICK, 8'hED, 1'b0, 32'h0, 1'b0));
        pending_reqs.push_back(mk_req(stsb_pkg::REQ_STOP, 8'h77, 1'b0, 32'd0, 1'b0));
        pending_reqs.push_back(mk_req(stsb_pkg::REQ_STOP, 8'hFF, 1'b0, 32'hFFFF_FFFF, 1'b1));
        pending_reqs.push_back(mk_req(3'd5, 8'h3C, 1'b1, 32'd5, 1'b1));
        pending_reqs.push_back(mk_req(3'd7, 8'hC3, 1'b0, 32'd5, 1'b0));
        for (int i = 0; i < 17; i++)
            pending_reqs.push_back(mk_req(stsb_pkg::REQ_START, 8'(i + 16), 1'b0, 32'd2, 1'b1));
        pending_reqs.push_back(mk_req(stsb_pkg::REQ_START, 8'd16, 1'b0, 32'd3, 1'b0));
        pending_reqs.push_back(mk_req(stsb_pkg::REQ_MS_TICK, 8'h0, 1'b0, 32'd0, 1'b0));
        pending_reqs.push_back(mk_req(stsb_pkg::REQ_MS_TICK, 8'h0, 1'b0, 32'd0, 1'b0));
        wait_drained();

        // long receiver hold-off while the sender keeps offering items
        for (int i = 0; i < 16; i++)
            pending_reqs.push_back(mk_req(stsb_pkg::REQ_STOP, 8'(i + 16), 1'b0, 32'd0, 1'b0));
        @(negedge clk);
        hold_off = 300;
        wait_drained();

        // random part, with a drain pause half way
        for (int n = 0; n < 62; n++)
        begin
            pending_reqs.push_back(rand_req());
            if (n == 31)
                wait_drained();
            while (pending_reqs.size() > 4)
                @(posedge clk);
        end
        wait_drained();
        repeat (40) @(posedge clk);

        $display("covered %0d requests, %0d output items of which %0d timer expiries",
                 accepted_reqs, seen_events, expiries);
        if (errors == 0 && expected_events.size() == 0)
            $display("software_timer_slot_bank_top_test passed");
        else
            $display("software_timer_slot_bank_top_test failed");
        $finish;
    end
endmodule

/* software_timer_slot_bank_top.f */
+incdir+hw/rtl
hw/rtl/stsb_pkg.sv
hw/rtl/stsb_datapath.sv
hw/rtl/stsb_ctrl.sv
hw/rtl/software_timer_slot_bank_top.sv
dv/software_timer_slot_bank_top_test.sv
